>>> rtl/stng_pkg.sv
// Package for the square tone and noise sound generator.
// Holds the shared types, register codes and the attenuation table.
// Used by stng_state, stng_mix and the top level; depends on nothing.
package stng_pkg;

   // Item kinds carried in the request tuser bit.
   localparam logic CMD_TICK  = 1'b0;
   localparam logic CMD_WRITE = 1'b1;

   // Chip register selects of a latch byte.
   localparam logic [2:0] REG_TONE0_PERIOD = 3'd0;
   localparam logic [2:0] REG_TONE0_ATT    = 3'd1;
   localparam logic [2:0] REG_TONE1_PERIOD = 3'd2;
   localparam logic [2:0] REG_TONE1_ATT    = 3'd3;
   localparam logic [2:0] REG_TONE2_PERIOD = 3'd4;
   localparam logic [2:0] REG_TONE2_ATT    = 3'd5;
   localparam logic [2:0] REG_NOISE_CTRL   = 3'd6;
   localparam logic [2:0] REG_NOISE_ATT    = 3'd7;

   // Noise rate code that follows tone 2.
   localparam logic [1:0] NOISE_RATE_TONE2 = 2'd3;
   localparam logic [9:0] NOISE_BASE_PERIOD = 10'd16;
   localparam logic [15:0] LFSR_SEED = 16'h8000;

   // Configuration register indexes.
   localparam logic [1:0] CSR_PRE_AMP       = 2'd0;
   localparam logic [1:0] CSR_NOISE_BOOST   = 2'd1;
   localparam logic [1:0] CSR_STEREO_ENABLE = 2'd2;

   // Datapath widths.
   localparam int TABLE_W = 11;
   localparam int AMP_W   = 11;
   localparam int PROD_W  = TABLE_W + AMP_W;
   localparam int RECIP_W = 23;
   localparam int GAIN_W  = 15;
   localparam int LEVEL_W = 17;

   // floor(x / 100) == (x * DIV_RECIP) >> DIV_SHIFT for every x below 2**22.
   localparam logic [RECIP_W-1:0] DIV_RECIP = 23'd5368710;
   localparam int DIV_SHIFT = 29;

   localparam logic [TABLE_W-1:0] ATT_TABLE [16] = '{
      11'd1516, 11'd1205, 11'd957, 11'd760, 11'd603, 11'd479, 11'd381, 11'd303,
      11'd240,  11'd191,  11'd152, 11'd120, 11'd96,  11'd76,  11'd60,  11'd0
   };

   // Per-item view of the channels handed from the state to the mixer.
   typedef struct packed {
      logic [3:0][3:0] att;   // attenuation of channels 3..0
      logic [3:0]      pos;   // tone polarity 2..0, noise output in bit 3
   } snap_type;

   typedef struct packed {
      logic [7:0] pre_amp;
      logic [1:0] noise_boost;
      logic [7:0] stereo_enable;
   } cfg_type;

endpackage

>>> rtl/stng_state.sv
// Channel state of the sound generator: periods, counters, polarities, LFSR.
// Applies one tick or one register byte per transfer and registers a snapshot.
// Depends on stng_pkg.
module stng_state
   import stng_pkg::*;
#(
   parameter int LFSR_WIDTH = 16
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic       cmd,
   input  logic [7:0] data_byte,
   output logic       snap_valid,
   input  logic       snap_ready,
   output snap_type   snap
);

   localparam int LFSR_REG_W = (LFSR_WIDTH > 16) ? LFSR_WIDTH : 16;

   logic [2:0][9:0]        tone_period_ff, tone_period_in;
   logic [3:0][3:0]        att_ff, att_in;
   logic [2:0]             noise_ctrl_ff, noise_ctrl_in;
   logic [2:0]             latch_ff, latch_in;
   logic [3:0][9:0]        count_ff, count_in;
   logic [3:0]             pol_ff, pol_in;
   logic [LFSR_REG_W-1:0]  lfsr_ff, lfsr_in;
   logic                   snap_valid_ff;
   snap_type               snap_ff, snap_in;
   logic                   accept;

   assign req_ready  = !snap_valid_ff || snap_ready;
   assign accept     = req_valid && req_ready;
   assign snap_valid = snap_valid_ff;
   assign snap       = snap_ff;

   always_comb begin
      logic [2:0] idx;
      logic [9:0] period;
      logic [9:0] nper;
      logic [9:0] ncount;
      logic       fb;
      tone_period_in = tone_period_ff;
      att_in         = att_ff;
      noise_ctrl_in  = noise_ctrl_ff;
      latch_in       = latch_ff;
      count_in       = count_ff;
      pol_in         = pol_ff;
      lfsr_in        = lfsr_ff;
      idx            = data_byte[7] ? data_byte[6:4] : latch_ff;
      period         = tone_period_ff[idx[2:1]];
      nper           = NOISE_BASE_PERIOD << noise_ctrl_ff[1:0];
      ncount         = count_ff[3];
      fb             = noise_ctrl_ff[2] ? (lfsr_ff[0] ^ lfsr_ff[3]) : lfsr_ff[0];
      if (cmd == CMD_WRITE) begin
         if (data_byte[7]) begin
            latch_in = data_byte[6:4];
         end
         case (idx)
            REG_NOISE_CTRL: begin
               noise_ctrl_in = data_byte[2:0];
               lfsr_in       = LFSR_REG_W'(LFSR_SEED);
            end
            REG_NOISE_ATT: begin
               att_in[3] = data_byte[3:0];
            end
            REG_TONE0_ATT, REG_TONE1_ATT, REG_TONE2_ATT: begin
               att_in[idx[2:1]] = data_byte[3:0];
            end
            default: begin
               if (data_byte[7]) begin
                  period = {period[9:4], data_byte[3:0]};
               end else begin
                  period = {data_byte[5:0], period[3:0]};
               end
               if (period == 10'd0) begin
                  period = 10'd1;
               end
               tone_period_in[idx[2:1]] = period;
            end
         endcase
      end else begin
         // Rate 3 borrows tone 2's period and the count it held before this tick.
         if (noise_ctrl_ff[1:0] == NOISE_RATE_TONE2) begin
            nper   = tone_period_ff[2];
            ncount = count_ff[2];
         end
         if (ncount == 10'd0) begin
            pol_in[3]   = !pol_ff[3];
            count_in[3] = nper - 10'd1;
            if (!pol_ff[3]) begin
               lfsr_in = (lfsr_ff >> 1) | (LFSR_REG_W'(fb) << (LFSR_WIDTH - 1));
            end
         end else begin
            count_in[3] = ncount - 10'd1;
         end
         for (int ch = 0; ch < 3; ch++) begin
            if (count_ff[ch] == 10'd0) begin
               pol_in[ch]   = (tone_period_ff[ch] > 10'd1) ? !pol_ff[ch] : 1'b1;
               count_in[ch] = tone_period_ff[ch] - 10'd1;
            end else begin
               count_in[ch] = count_ff[ch] - 10'd1;
            end
         end
      end
      snap_in.att = att_in;
      snap_in.pos = {lfsr_in[0], pol_in[2:0]};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tone_period_ff <= {3{10'd1}};
         att_ff         <= {4{4'hf}};
         noise_ctrl_ff  <= 3'd0;
         latch_ff       <= 3'd0;
         count_ff       <= '0;
         pol_ff         <= 4'hf;
         lfsr_ff        <= LFSR_REG_W'(LFSR_SEED);
         snap_valid_ff  <= 1'b0;
      end else begin
         if (req_ready) begin
            snap_valid_ff <= req_valid;
         end
         if (accept) begin
            tone_period_ff <= tone_period_in;
            att_ff         <= att_in;
            noise_ctrl_ff  <= noise_ctrl_in;
            latch_ff       <= latch_in;
            count_ff       <= count_in;
            pol_ff         <= pol_in;
            lfsr_ff        <= lfsr_in;
         end
      end
      if (accept) begin
         snap_ff <= snap_in;
      end
   end

   // A stored tone period is never zero, since a zero write becomes one.
   a_period_nonzero: assert property (@(posedge clock) disable iff (reset)
      tone_period_ff[0] != 10'd0 && tone_period_ff[1] != 10'd0 &&
      tone_period_ff[2] != 10'd0)
      else $error("tone period reached zero");

   // The shift register can never fall into the all-zero lockup state.
   a_lfsr_nonzero: assert property (@(posedge clock) disable iff (reset)
      lfsr_ff != '0)
      else $error("noise shift register is all zeros");

endmodule

>>> rtl/stng_mix.sv
// Mixer pipeline: channel gains, divide by 100 and signed sums per side.
// Three registered stages with their own valid bits; the last is the output.
// Depends on stng_pkg.
module stng_mix
   import stng_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  cfg_type                    cfg,
   input  logic                       snap_valid,
   output logic                       snap_ready,
   input  snap_type                   snap,
   output logic                       out_valid,
   input  logic                       out_ready,
   output logic signed [LEVEL_W-1:0]  left_level,
   output logic signed [LEVEL_W-1:0]  right_level
);

   logic [1:0][3:0][PROD_W-1:0]      prod_ff, prod_in;
   logic [1:0][3:0][GAIN_W-1:0]      gain_ff, gain_in;
   logic [3:0]                       pos2_ff, pos3_ff;
   logic [1:0][LEVEL_W-1:0]          level_ff, level_in;
   logic                             v2_ff, v3_ff, out_valid_ff;
   logic                             ready3, ready4;

   assign ready4     = !out_valid_ff || out_ready;
   assign ready3     = !v3_ff || ready4;
   assign snap_ready = !v2_ff || ready3;
   assign out_valid  = out_valid_ff;
   assign left_level  = $signed(level_ff[0]);
   assign right_level = $signed(level_ff[1]);

   // Side 0 is left (enable bits 7..4), side 1 is right (bits 3..0).
   always_comb begin
      logic             en;
      logic [AMP_W-1:0] amp;
      for (int s = 0; s < 2; s++) begin
         for (int ch = 0; ch < 4; ch++) begin
            en  = (s == 0) ? cfg.stereo_enable[ch + 4] : cfg.stereo_enable[ch];
            amp = en ? AMP_W'(cfg.pre_amp) : '0;
            if (ch == 3) begin
               amp = amp << cfg.noise_boost;
            end
            prod_in[s][ch] = PROD_W'(ATT_TABLE[snap.att[ch]]) * PROD_W'(amp);
         end
      end
   end

   always_comb begin
      logic [PROD_W+RECIP_W-1:0] q;
      for (int s = 0; s < 2; s++) begin
         for (int ch = 0; ch < 4; ch++) begin
            q = (PROD_W + RECIP_W)'(prod_ff[s][ch]) * (PROD_W + RECIP_W)'(DIV_RECIP);
            gain_in[s][ch] = GAIN_W'(q >> DIV_SHIFT);
         end
      end
   end

   always_comb begin
      logic signed [LEVEL_W-1:0] acc;
      logic signed [LEVEL_W-1:0] g;
      for (int s = 0; s < 2; s++) begin
         acc = '0;
         for (int ch = 0; ch < 3; ch++) begin
            g   = $signed(LEVEL_W'(gain_ff[s][ch]));
            acc = pos3_ff[ch] ? (acc + g) : (acc - g);
         end
         if (pos3_ff[3]) begin
            acc = acc + $signed(LEVEL_W'(gain_ff[s][3]));
         end
         level_in[s] = acc;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff        <= 1'b0;
         v3_ff        <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (snap_ready) begin
            v2_ff <= snap_valid;
         end
         if (ready3) begin
            v3_ff <= v2_ff;
         end
         if (ready4) begin
            out_valid_ff <= v3_ff;
         end
      end
      if (snap_ready && snap_valid) begin
         prod_ff <= prod_in;
         pos2_ff <= snap.pos;
      end
      if (ready3 && v2_ff) begin
         gain_ff <= gain_in;
         pos3_ff <= pos2_ff;
      end
      if (ready4 && v3_ff) begin
         level_ff <= level_in;
      end
   end

endmodule

>>> rtl/square_tone_noise_sound_generator.sv
// Top level of the square tone and noise sound generator.
// Holds the configuration registers and joins stng_state and stng_mix.
// Depends on stng_pkg, stng_state and stng_mix.
//
// Usage: each transfer on the req_ channel is either one divider tick
// (req_tuser = 0) or one register byte for the chip's latch/data protocol
// (req_tuser = 1, byte in req_tdata). Every request transfer yields exactly
// one rsp_ transfer carrying the mixed left and right levels as they stand
// after that request, in request order.
// A request transfer reaches rsp_tvalid through the channel state update
// register, the table-times-amplitude multipliers, the reciprocal multiply
// that divides by 100 and then the signed sum into the output register.
// Throughput is one item per cycle while rsp_tready is high; each stage
// has its own valid bit, so a result waiting on a stalled receiver does not
// block the stages behind it until they are all full, after which req_tready
// drops and holds the channel.
// Reset (synchronous, active high) returns the tone periods to one, all
// attenuations to silent, the counters to zero, polarities high, the noise
// register to its seed, and the configuration to its defaults; the pipeline
// is emptied. Configuration writes go through the csr_ port, only while no
// request is in flight: a rule for the user that the block does not enforce.
module square_tone_noise_sound_generator
   import stng_pkg::*;
#(
   parameter int LFSR_WIDTH = 16
) (
   input  logic        clock,
   input  logic        reset,
   // Request channel.
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] data_byte
   input  logic [0:0]  req_tuser,   // [0] cmd
   // Result channel.
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // [16:0] left_level, [33:17] right_level, rest zero
   // Configuration port.
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [3:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   logic [7:0]                pre_amp_ff;
   logic [1:0]                noise_boost_ff;
   logic [7:0]                stereo_enable_ff;
   cfg_type                   cfg;
   logic                      csr_write;
   logic                      snap_valid, snap_ready;
   snap_type                  snap;
   logic signed [LEVEL_W-1:0] left_level, right_level;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   assign cfg.pre_amp       = pre_amp_ff;
   assign cfg.noise_boost   = noise_boost_ff;
   assign cfg.stereo_enable = stereo_enable_ff;

   // Registers sit on word addresses; writes to the unused slot are dropped.
   always_ff @(posedge clock) begin
      if (reset) begin
         pre_amp_ff       <= 8'd100;
         noise_boost_ff   <= 2'd0;
         stereo_enable_ff <= 8'hff;
      end else if (csr_write) begin
         case (csr_paddr[3:2])
            CSR_PRE_AMP:       pre_amp_ff       <= csr_pwdata[7:0];
            CSR_NOISE_BOOST:   noise_boost_ff   <= csr_pwdata[1:0];
            CSR_STEREO_ENABLE: stereo_enable_ff <= csr_pwdata[7:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_paddr[3:2])
         CSR_PRE_AMP:       csr_prdata = {24'd0, pre_amp_ff};
         CSR_NOISE_BOOST:   csr_prdata = {30'd0, noise_boost_ff};
         CSR_STEREO_ENABLE: csr_prdata = {24'd0, stereo_enable_ff};
         default:           csr_prdata = 32'd0;
      endcase
   end

   stng_state #(
      .LFSR_WIDTH (LFSR_WIDTH)
   ) u_state (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_tvalid),
      .req_ready  (req_tready),
      .cmd        (req_tuser[0]),
      .data_byte  (req_tdata),
      .snap_valid (snap_valid),
      .snap_ready (snap_ready),
      .snap       (snap)
   );

   stng_mix u_mix (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg),
      .snap_valid  (snap_valid),
      .snap_ready  (snap_ready),
      .snap        (snap),
      .out_valid   (rsp_tvalid),
      .out_ready   (rsp_tready),
      .left_level  (left_level),
      .right_level (right_level)
   );

   assign rsp_tdata = {6'd0, right_level, left_level};

   // With no result waiting every stage can move, so a request is always taken.
   a_ready_when_drained: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("request stalled while output is empty");

   // Reset empties the pipeline.
   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid right after reset");

endmodule
